FILE: rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/d2h_pkg.sv
`default_nettype none
package d2h_pkg;
	localparam int unsigned DFracW = 52;
	localparam int unsigned HFracW = 10;
	localparam int unsigned DropW = DFracW - HFracW;
	localparam logic [10:0] DExpAll = 11'h7FF;
	localparam logic [14:0] HInf = 15'h7C00;
	localparam logic [14:0] HQnanFrac = 15'h0200;
	// rebias: half exp = dexp - 1023 + 15 = dexp - 1008
	localparam logic [11:0] Rebias = 12'd1008;
	localparam logic [11:0] HExpOvf = 12'd31;

	typedef enum logic [1:0] {
		K_NORM,
		K_SUB,
		K_FIXED
	} kind_t;

	// stage 1 -> stage 2 decoded operand
	typedef struct packed {
		logic        sign;
		kind_t       kind;
		logic [14:0] fixed;  // result magnitude when kind is fixed
		logic [4:0]  hexp;   // normal path exponent
		logic [52:0] sig;    // significand with hidden bit
		logic [5:0]  sh;     // subnormal shift, 43..63
	} dec_t;
endpackage
`default_nettype wire

FILE: rtl/d2h_round.sv
`default_nettype none
// Stages 2 and 3: align, then round to nearest even.
module d2h_round (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vld_s1,
	input  wire d2h_pkg::dec_t dec_s1,
	output logic               vld_s3,
	output logic [15:0]        half_s3
);
	logic [63:0] sig_ext;
	logic [63:0] shifted;
	logic [63:0] rem_full;
	logic [63:0] lowmask;
	logic [10:0] q_c;
	logic        rbit_c, sticky_c;

	logic        vld_s2;
	logic        sign_s2;
	d2h_pkg::kind_t kind_s2;
	logic [14:0] fixed_s2;
	logic [10:0] q_s2;
	logic        rbit_s2, sticky_s2;
	logic [4:0]  hexp_s2;

	logic [14:0] base_c;
	logic        inc_c;

	assign sig_ext = {11'd0, dec_s1.sig};
	assign lowmask = (64'd1 << dec_s1.sh) - 64'd1;
	assign shifted = sig_ext >> dec_s1.sh;
	assign rem_full = sig_ext & lowmask;

	always_comb begin
		if (dec_s1.kind == d2h_pkg::K_NORM) begin
			q_c = {1'b0, dec_s1.sig[51:42]};
			rbit_c = dec_s1.sig[41];
			sticky_c = |dec_s1.sig[40:0];
		end else begin
			q_c = shifted[10:0];
			rbit_c = |(rem_full & (64'd1 << (dec_s1.sh - 6'd1)));
			sticky_c = |(rem_full & (lowmask >> 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sign_s2 <= dec_s1.sign;
		kind_s2 <= dec_s1.kind;
		fixed_s2 <= dec_s1.fixed;
		hexp_s2 <= dec_s1.hexp;
		q_s2 <= q_c;
		rbit_s2 <= rbit_c;
		sticky_s2 <= sticky_c;
	end

	always_comb begin
		case (kind_s2)
			d2h_pkg::K_NORM: base_c = {hexp_s2, q_s2[9:0]};
			default:         base_c = {4'd0, q_s2};
		endcase
		inc_c = rbit_s2 && (sticky_s2 || base_c[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (kind_s2 == d2h_pkg::K_FIXED) begin
			half_s3 <= {sign_s2, fixed_s2};
		end else begin
			half_s3 <= {sign_s2, base_c + {14'd0, inc_c}};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/double_to_half_convert.sv
// binary64 to binary16 conversion, round to nearest even.
// Stages from start to done: decode, align, round.
// Throughput: one request per cycle; busy is always low.
// Reset: arst_n clears the stage valid bits only; the receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"
module double_to_half_convert (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] double_bits,
	output logic             done,
	output logic [15:0]      half_bits
);
	logic [10:0] ex;
	logic [11:0] ex_w;
	logic [11:0] e_neg;
	d2h_pkg::dec_t dec_c;
	d2h_pkg::dec_t dec_s1;
	logic vld_s1;

	assign busy = 1'b0;
	assign ex = double_bits[62:52];
	assign ex_w = {1'b0, ex};
	assign e_neg = d2h_pkg::Rebias - ex_w; // -e when e <= 0

	always_comb begin
		dec_c.sign = double_bits[63];
		dec_c.kind = d2h_pkg::K_FIXED;
		dec_c.fixed = 15'd0;
		dec_c.hexp = 5'(ex_w - d2h_pkg::Rebias);
		dec_c.sig = {1'b1, double_bits[51:0]};
		dec_c.sh = 6'd43;
		if (ex == d2h_pkg::DExpAll) begin
			dec_c.fixed = d2h_pkg::HInf |
				((|double_bits[51:0]) ? d2h_pkg::HQnanFrac : 15'd0);
		end else if (ex_w >= d2h_pkg::Rebias + d2h_pkg::HExpOvf) begin
			dec_c.fixed = d2h_pkg::HInf;
		end else if (ex_w > d2h_pkg::Rebias) begin
			dec_c.kind = d2h_pkg::K_NORM;
		end else if (ex != 11'd0 && e_neg < 12'd21) begin
			dec_c.kind = d2h_pkg::K_SUB;
			dec_c.sh = 6'(12'd43 + e_neg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1 <= dec_c;
	end

	d2h_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.dec_s1 (dec_s1),
		.vld_s3 (done),
		.half_s3(half_bits)
	);

	`ASSERT_NEXT(a_lat1, clk, arst_n, start, vld_s1)
	`ASSERT_NEXT(a_lat3, clk, arst_n, vld_s1, ##1 done)
	`ASSERT_NEXT(a_no_req, clk, arst_n, !start, !vld_s1)
	`ASSERT_IMPLIES(a_busy_low, clk, arst_n, 1'b1, !busy)
endmodule
`default_nettype wire

FILE: dv/d2h_checker.sv
`default_nettype none
module d2h_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [63:0] double_bits,
	input  wire logic        done,
	input  wire logic [15:0] half_bits,
	output int               fail_count,
	output int               pending,
	output int               seen_count
);
	logic [15:0] half_q[$];

	// round to nearest even, v >> sh with sh in 1..63
	function automatic logic [63:0] rne_shift(logic [63:0] v, int sh);
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		q = v >> sh;
		rem = v & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 64'd1;
		return q;
	endfunction

	function automatic logic [15:0] to_half(logic [63:0] d);
		logic [10:0] dexp;
		logic [51:0] frac;
		logic [63:0] mag;
		int e;
		int sh;
		dexp = d[62:52];
		frac = d[51:0];
		if (dexp == 11'h7FF) begin
			mag = (frac != 0) ? 64'h7E00 : 64'h7C00;
		end else begin
			e = int'(dexp) - 1023 + 15;
			if (e >= 31) begin
				mag = 64'h7C00;
			end else if (e <= 0) begin
				sh = 43 - e;
				if (dexp == 0 || sh >= 64)
					mag = 0;
				else
					mag = rne_shift({11'd0, 1'b1, frac}, sh);
			end else begin
				// exponent and fraction together so rounding can carry
				mag = rne_shift({7'd0, e[4:0], frac}, 42);
			end
		end
		return {d[63], mag[14:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			seen_count <= 0;
			half_q.delete();
		end else begin
			if (start && !busy)
				half_q.push_back(to_half(double_bits));
			if (done) begin
				seen_count <= seen_count + 1;
				if (half_q.size() == 0 && !(start && !busy)) begin
					$error("unexpected result half_bits=%h", half_bits);
					fail_count <= fail_count + 1;
				end else begin
					want = half_q.pop_front();
					if (want !== half_bits) begin
						$error("half_bits: expected %h, actual %h", want, half_bits);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= half_q.size();
		end
	end
endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [63:0] double_bits = '0;
	logic        busy;
	logic        done;
	logic [15:0] half_bits;
	int          fail_count;
	int          pending;
	int          seen_count;
	int          sent;

	always #5 clk = ~clk;

	double_to_half_convert u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.double_bits(double_bits), .done(done), .half_bits(half_bits)
	);

	d2h_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.double_bits(double_bits), .done(done), .half_bits(half_bits),
		.fail_count(fail_count), .pending(pending), .seen_count(seen_count)
	);

	// start stays high across back-to-back requests
	task automatic send_request(logic [63:0] v, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		double_bits <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_double();
		logic [63:0] r;
		int unsigned e;
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2: e = $urandom_range(1038, 1008);      // normal half range (1008 is subnormal)
			3, 4: e = $urandom_range(1008, 980);          // subnormal and tiny
			5: e = $urandom_range(1040, 1037);            // overflow edge
			6: e = $urandom_range(1) ? 32'h7FF : 32'h000;
			default: e = $urandom_range(2047);
		endcase
		r[62:52] = e[10:0];
		// bias the dropped bits toward ties
		if ($urandom_range(3) == 0)
			r[41:0] = {1'b1, 41'd0} | ($urandom_range(1) ? 42'd0 : 42'd1);
		return r;
	endfunction

	initial begin
		logic [63:0] dir[$];
		sent = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		dir = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000, 64'h40EF_FC00_0000_0000,
			64'h40EF_FE00_0000_0000, 64'h40EF_FDFF_FFFF_FFFF, 64'h40F0_0000_0000_0000,
			64'h3F10_0000_0000_0000, 64'h3E70_0000_0000_0000, 64'h3E60_0000_0000_0000,
			64'h3E60_0000_0000_0001, 64'h3E50_0000_0000_0000, 64'h3F0F_FF00_0000_0000,
			64'h3F0F_FE00_0000_0000, 64'h3FF0_0200_0000_0000, 64'h3FF0_0600_0000_0000,
			64'h7FEF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
		foreach (dir[i])
			send_request(dir[i], 0);
		start <= 1'b0;
		wait (pending == 0);
		repeat (5) @(negedge clk);
		for (int i = 0; i < 470; i++)
			send_request(rand_double(), 14);
		for (int i = 0; i < 470; i++)
			send_request(rand_double(), 85);
		for (int i = 0; i < 470; i++)
			send_request(rand_double(), 0);
		start <= 1'b0;
		wait (pending == 0);
		repeat (10) @(posedge clk);
		$display("Converted %0d doubles (zeros, subnormals, NaN/inf, overflow, ties)", sent);
		$display("and checked %0d half results.", seen_count);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
